### design/assert_macros.svh
// Assertion macros included by double_aligned_bitwise_and.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/daba_pkg.sv
// Package with constants and types for the aligned double AND.
package daba_pkg;
   localparam int FracBits = 52;
   localparam int ExpBits = 11;
   localparam int WordBits = 64;
   localparam int MantBits = 53;
   localparam int LeadBits = 6;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [ExpBits-1:0] exp_type;
   typedef logic [MantBits-1:0] mant_type;
   typedef logic [LeadBits-1:0] lead_type;

   // Position of the leading one in a 53-bit value (0 if none).
   function automatic lead_type lead_pos(input mant_type m);
      lead_type p;
      p = '0;
      for (int i = 0; i < MantBits; i++) begin
         if (m[i]) begin
            p = LeadBits'(i);
         end
      end
      return p;
   endfunction
endpackage

### design/double_aligned_bitwise_and.sv
// Stages: align, mask, lead, norm; rsp_valid and the result come from the norm stage registers.
// Throughput: one request per cycle; a stall with a result waiting freezes the whole pipeline.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
// Stage 1 orders operands, stage 2 shifts and ANDs, stage 3 finds the leading one,
// stage 4 renormalizes with subnormal saturation, or passes the raw AND when exponents are equal.
`include "assert_macros.svh"
module double_aligned_bitwise_and (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  daba_pkg::word_type     req_operand_a,
   input  daba_pkg::word_type     req_operand_b,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output daba_pkg::word_type     rsp_and_result
);
   import daba_pkg::*;

   logic adv;
   assign adv = !rsp_stall || !rsp_valid;
   assign req_stall = !adv;

   // Stage 1: order by exponent.
   logic     v1_ff, v1_in;
   logic     eq1_ff, eq1_in;
   logic     sgn1_ff, sgn1_in;
   logic     far1_ff, far1_in;
   word_type raw1_ff, raw1_in;
   logic [FracBits-1:0] bigf1_ff, bigf1_in;
   mant_type smallm1_ff, smallm1_in;
   lead_type gap1_ff, gap1_in;
   exp_type  elow1_ff, elow1_in;

   always_comb begin
      exp_type ea, eb;
      logic [ExpBits-1:0] gap;
      ea = req_operand_a[WordBits-2 -: ExpBits];
      eb = req_operand_b[WordBits-2 -: ExpBits];
      v1_in = req_valid;
      eq1_in = (ea == eb);
      raw1_in = req_operand_a & req_operand_b;
      sgn1_in = (req_operand_a[WordBits-2:0] != '0) && (req_operand_b[WordBits-2:0] != '0)
                && req_operand_a[WordBits-1] && req_operand_b[WordBits-1];
      if (ea > eb) begin
         gap = ea - eb;
         bigf1_in = req_operand_a[FracBits-1:0];
         smallm1_in = {(eb != '0), req_operand_b[FracBits-1:0]};
         elow1_in = eb;
      end else begin
         gap = eb - ea;
         bigf1_in = req_operand_b[FracBits-1:0];
         smallm1_in = {(ea != '0), req_operand_a[FracBits-1:0]};
         elow1_in = ea;
      end
      far1_in = (gap > ExpBits'(FracBits));
      gap1_in = gap[LeadBits-1:0];
   end

   // Stage 2: shift and mask.
   logic     v2_ff, eq2_ff, sgn2_ff;
   word_type raw2_ff;
   mant_type m2_ff, m2_in;
   exp_type  elow2_ff;

   always_comb begin
      logic [WordBits+FracBits-1:0] sh;
      sh = {{WordBits{1'b0}}, bigf1_ff} << gap1_ff;
      m2_in = far1_ff ? '0 : (sh[MantBits-1:0] & smallm1_ff);
   end

   // Stage 3: leading-one search.
   logic     v3_ff, eq3_ff, sgn3_ff;
   word_type raw3_ff;
   mant_type m3_ff;
   exp_type  elow3_ff;
   lead_type lead3_ff, lead3_in;
   assign lead3_in = lead_pos(m2_ff);

   // Stage 4: normalize.
   logic     v4_ff;
   word_type res4_ff, res4_in;

   always_comb begin
      lead_type norm;
      exp_type  sh;
      mant_type ms;
      norm = LeadBits'(FracBits) - lead3_ff;
      sh = '0;
      ms = '0;
      res4_in = {sgn3_ff, {(WordBits-1){1'b0}}};
      if (eq3_ff) begin
         res4_in = raw3_ff;
      end else if (m3_ff != '0) begin
         if (norm == '0) begin
            res4_in = {sgn3_ff, elow3_ff, m3_ff[FracBits-1:0]};
         end else if (ExpBits'(norm) >= elow3_ff) begin
            if (elow3_ff != '0) begin
               sh = elow3_ff - ExpBits'(1);
            end
            ms = m3_ff << sh[LeadBits-1:0];
            res4_in = {sgn3_ff, {ExpBits{1'b0}}, ms[FracBits-1:0]};
         end else begin
            ms = m3_ff << norm;
            res4_in = {sgn3_ff, elow3_ff - ExpBits'(norm), ms[FracBits-1:0]};
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         eq1_ff <= eq1_in;
         sgn1_ff <= sgn1_in;
         far1_ff <= far1_in;
         raw1_ff <= raw1_in;
         bigf1_ff <= bigf1_in;
         smallm1_ff <= smallm1_in;
         gap1_ff <= gap1_in;
         elow1_ff <= elow1_in;
         eq2_ff <= eq1_ff;
         sgn2_ff <= sgn1_ff;
         raw2_ff <= raw1_ff;
         m2_ff <= m2_in;
         elow2_ff <= elow1_ff;
         eq3_ff <= eq2_ff;
         sgn3_ff <= sgn2_ff;
         raw3_ff <= raw2_ff;
         m3_ff <= m2_ff;
         elow3_ff <= elow2_ff;
         lead3_ff <= lead3_in;
         res4_ff <= res4_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_and_result = res4_ff;

   // Checks.
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall && rsp_valid, $stable(rsp_and_result))
   `ASSERT_IMPL(a_far_zero, clock, reset, v2_ff && !eq2_ff && $past(far1_ff && adv), m2_ff == '0)
   `ASSERT_IMPL(a_lead_top, clock, reset, v3_ff && m3_ff != '0, m3_ff[lead3_ff] == 1'b1)
endmodule
